@@ rtl/tprq_pkg.sv @@
// ----------------------------------------------------------------------------
// tprq_pkg: shared types and constants of the thread priority ready queue
// Entry layout, operation codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package tprq_pkg;

	localparam int MAX_ENTRIES  = 16;
	localparam int ID_BITS      = 8;
	localparam int QUANTUM_BITS = 16;
	localparam int IDX_BITS     = $clog2(MAX_ENTRIES);
	localparam int CNT_BITS     = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_BITS   = ID_BITS + QUANTUM_BITS + 2 + 1 + ID_BITS;

	localparam logic [2:0] FUNC_ENQ    = 3'd0;
	localparam logic [2:0] FUNC_DEQ    = 3'd1;
	localparam logic [2:0] FUNC_WAKE   = 3'd2;
	localparam logic [2:0] FUNC_CHKFIN = 3'd3;
	localparam logic [2:0] FUNC_LOOKUP = 3'd4;
	localparam logic [2:0] FUNC_SETST  = 3'd5;

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_SLEEP = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;

	typedef struct packed {
		logic [ID_BITS-1:0]      tid;
		logic [QUANTUM_BITS-1:0] quantum;
		logic [1:0]              status;
		logic                    wait_valid;
		logic [ID_BITS-1:0]      wait_id;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE_RD,
		S_MOVE_WR,
		S_PUT,
		S_DONE
	} state_t;

endpackage

@@ rtl/tprq_ram.sv @@
// ----------------------------------------------------------------------------
// tprq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tprq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/thread_priority_ready_queue.sv @@
// ----------------------------------------------------------------------------
// thread_priority_ready_queue: ready queue sorted by quantum used
// Entry table in one RAM, scanned by a small sequencer one entry a cycle.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one operation per transfer; tdata holds func, thread_id,
//  quantum, status, waiting_valid and waiting_id. m_axis returns exactly one
//  result per operation; tdata holds found, the entry fields and error.
//  Only one operation is in flight: s_axis_tready is high only while idle with no result waiting.
//  Steps per operation: lookup and set status scan one read a cycle until
//   the thread id is found (set status writes it back) or the table ends;
//   wake and check finished scan the whole table, wake writing back each
//   match in the same pass. enqueue scans to the insert point, then takes a
//   read and a write state per shifted entry, then S_PUT. dequeue scans to
//   the first runnable entry, then takes a read and a write state per entry
//   moved up. All end in S_DONE, which loads the result. Worst case: an
//   enqueue at the head of a table holding MAX_ENTRIES - 1 entries.
//  The next operation can be taken in the cycle after the result transfer.
//  All entries pass the single RAM port pair (one read, one write per cycle).
//  Reset clears the entry count, state and output valid, not the table RAM.
//  When m_axis_tready is low the result is held in the output register and
//  no new operation is accepted until it is taken.
// ----------------------------------------------------------------------------
module thread_priority_ready_queue
	import tprq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// func[2:0], thread_id[10:3], quantum[26:11], status[28:27],
	// waiting_valid[29], waiting_id[37:30], zero fill [39:38]
	input  logic [39:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found[0], out_thread_id[8:1], out_quantum[24:9], out_status[26:25],
	// out_waiting_valid[27], out_waiting_id[35:28], error[36], zero fill [39:37]
	output logic [39:0]  m_axis_tdata
);

	state_t state_q, state_d;

	// operation registers
	logic [2:0]              func_q;
	logic [ID_BITS-1:0]      id_q;
	entry_t                  new_q;
	logic [CNT_BITS-1:0]     count_q;
	logic [CNT_BITS-1:0]     ptr_q;   // scan or move index
	logic [CNT_BITS-1:0]     pos_q;   // insert or remove position
	logic                    rd_pend_q;
	logic [IDX_BITS-1:0]     rd_idx_q;

	// result registers
	logic                    found_q;
	logic                    err_q;
	entry_t                  res_q;
	logic                    out_valid_q;

	// RAM port
	logic                    we;
	logic [IDX_BITS-1:0]     waddr, raddr;
	entry_t                  wdata, rdata;

	tprq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	logic s_fire;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;

	// scan decisions on the entry read last cycle
	logic id_hit, run_hit, wake_hit, done_hit, enq_hit;
	logic [IDX_BITS-1:0] scan_idx;
	assign scan_idx = rd_idx_q;
	assign id_hit   = rdata.tid == id_q;
	assign run_hit  = rdata.status == ST_RUN;
	assign wake_hit = rdata.status == ST_SLEEP && rdata.wait_valid && rdata.wait_id == id_q;
	assign done_hit = id_hit && rdata.status == ST_DONE;
	assign enq_hit  = (scan_idx == '0) ? (new_q.quantum < rdata.quantum)
	                                   : !(rdata.quantum < new_q.quantum);

	entry_t woken;
	always_comb begin
		woken            = rdata;
		woken.status     = ST_RUN;
		woken.wait_valid = 1'b0;
		woken.wait_id    = '0;
	end

	entry_t set_e;
	always_comb begin
		set_e            = rdata;
		set_e.status     = new_q.status;
		set_e.wait_valid = new_q.wait_valid;
		set_e.wait_id    = new_q.wait_id;
	end

	// next state, RAM control and result updates
	logic                found_d, err_d, rd_pend_d, out_load;
	entry_t              res_d;
	logic [CNT_BITS-1:0] ptr_d, pos_d, count_d;

	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		waddr     = scan_idx;
		wdata     = rdata;
		raddr     = ptr_q[IDX_BITS-1:0];
		rd_pend_d = 1'b0;
		ptr_d     = ptr_q;
		pos_d     = pos_q;
		count_d   = count_q;
		found_d   = found_q;
		err_d     = err_q;
		res_d     = res_q;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_fire) begin
					ptr_d   = '0;
					found_d = 1'b0;
					err_d   = 1'b0;
					res_d   = '0;
					if (s_axis_tdata[2:0] == FUNC_ENQ && count_q == CNT_BITS'(MAX_ENTRIES)) begin
						err_d   = 1'b1;
						state_d = S_DONE;
					end else if (s_axis_tdata[2:0] > FUNC_SETST) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				// issue next read, evaluate the previous one
				if (ptr_q < count_q) begin
					rd_pend_d = 1'b1;
					ptr_d     = ptr_q + 1'b1;
				end
				if (rd_pend_q) begin
					case (func_q)
						FUNC_ENQ: begin
							if (enq_hit) begin
								pos_d     = CNT_BITS'(scan_idx);
								ptr_d     = count_q;
								rd_pend_d = 1'b0;
								state_d   = S_MOVE_RD;
							end
						end
						FUNC_DEQ: begin
							if (run_hit) begin
								found_d   = 1'b1;
								res_d     = rdata;
								ptr_d     = CNT_BITS'(scan_idx) + 1'b1;
								rd_pend_d = 1'b0;
								state_d   = S_MOVE_RD;
							end
						end
						FUNC_WAKE: begin
							if (wake_hit) begin
								we      = 1'b1;
								wdata   = woken;
								found_d = 1'b1;
							end
						end
						FUNC_CHKFIN: begin
							if (done_hit) begin
								found_d = 1'b1;
							end
						end
						FUNC_LOOKUP: begin
							if (id_hit) begin
								found_d   = 1'b1;
								res_d     = rdata;
								rd_pend_d = 1'b0;
								state_d   = S_DONE;
							end
						end
						FUNC_SETST: begin
							if (id_hit) begin
								we        = 1'b1;
								wdata     = set_e;
								found_d   = 1'b1;
								res_d     = set_e;
								rd_pend_d = 1'b0;
								state_d   = S_DONE;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
				// end of table reached with nothing pending
				if (state_d == S_SCAN && !rd_pend_d) begin
					if (func_q == FUNC_ENQ) begin
						pos_d   = count_q;
						state_d = S_PUT;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_MOVE_RD: begin
				// enqueue shifts down from the tail, dequeue shifts up
				if (func_q == FUNC_ENQ) begin
					if (ptr_q == pos_q) begin
						state_d = S_PUT;
					end else begin
						raddr   = IDX_BITS'(ptr_q - 1'b1);
						state_d = S_MOVE_WR;
					end
				end else begin
					if (ptr_q >= count_q) begin
						count_d = count_q - 1'b1;
						state_d = S_DONE;
					end else begin
						raddr   = ptr_q[IDX_BITS-1:0];
						state_d = S_MOVE_WR;
					end
				end
			end
			S_MOVE_WR: begin
				we = 1'b1;
				if (func_q == FUNC_ENQ) begin
					waddr = ptr_q[IDX_BITS-1:0];
					ptr_d = ptr_q - 1'b1;
				end else begin
					waddr = IDX_BITS'(ptr_q - 1'b1);
					ptr_d = ptr_q + 1'b1;
				end
				state_d = S_MOVE_RD;
			end
			S_PUT: begin
				we      = 1'b1;
				waddr   = pos_q[IDX_BITS-1:0];
				wdata   = new_q;
				count_d = count_q + 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				out_load = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			rd_pend_q <= rd_pend_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			func_q             <= s_axis_tdata[2:0];
			id_q               <= s_axis_tdata[10:3];
			new_q.tid          <= s_axis_tdata[10:3];
			new_q.quantum      <= s_axis_tdata[26:11];
			new_q.status       <= s_axis_tdata[28:27];
			new_q.wait_valid   <= s_axis_tdata[29];
			new_q.wait_id      <= s_axis_tdata[37:30];
		end
		ptr_q    <= ptr_d;
		pos_q    <= pos_d;
		rd_idx_q <= raddr;
		found_q  <= found_d;
		err_q    <= err_d;
		res_q    <= res_d;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, err_q, res_q.wait_id, res_q.wait_valid, res_q.status,
	                        res_q.quantum, res_q.tid, found_q};

endmodule
